// File: rtl/core/countdown_timer_motion_watchdog_unit_defines.svh
// Assertion helpers used by countdown_timer_motion_watchdog_unit.sv.
`ifndef COUNTDOWN_TIMER_MOTION_WATCHDOG_UNIT_DEFINES_SVH
`define COUNTDOWN_TIMER_MOTION_WATCHDOG_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Check with reset disable.
`define CTWD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that also holds during reset.
`define CTWD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CTWD_ASSERT(label, clk, rst, prop, msg)
`define CTWD_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// File: rtl/core/ctwd_pkg.sv
`default_nettype none

package ctwd_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;
   localparam int DISPLAY_W   = 14;

   // Request commands
   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_START = 2'd1;
   localparam logic [1:0] CMD_STOP  = 2'd2;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESET_HOURS_TENS   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESET_HOURS_ONES   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESET_MINUTES_TENS = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESET_MINUTES_ONES = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BUZZER_LENGTH       = 3'd4;

   localparam logic [3:0] DIGIT_TOP        = 4'd9;
   localparam logic [2:0] MINUTES_TENS_TOP = 3'd5;
   localparam logic [5:0] SECONDS_TOP      = 6'd59;
   localparam logic [7:0] BUZZER_LENGTH_RESET = 8'd120;

   typedef struct packed {
      logic [3:0] hours_tens;
      logic [3:0] hours_ones;
      logic [2:0] minutes_tens;
      logic [3:0] minutes_ones;
   } time_digits_type;

   localparam time_digits_type DIGITS_RESET = '{
      hours_tens: 4'd1, hours_ones: 4'd2, minutes_tens: 3'd3, minutes_ones: 4'd4
   };

endpackage

`default_nettype wire

// File: rtl/core/ctwd_req_if.sv
`default_nettype none

interface ctwd_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic       sensor_level;

   modport source (output valid, output cmd, output sensor_level, input ready);
   modport sink   (input valid, input cmd, input sensor_level, output ready);
endinterface

`default_nettype wire

// File: rtl/core/ctwd_rsp_if.sv
`default_nettype none

interface ctwd_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [ctwd_pkg::DISPLAY_W-1:0] display_value;
   logic                           running;
   logic                           buzzer_on;
   logic                           colon_on;
   logic                           motion_fault;
   logic                           finished;

   modport source (output valid, output display_value, output running, output buzzer_on,
                   output colon_on, output motion_fault, output finished, input ready);
   modport sink   (input valid, input display_value, input running, input buzzer_on,
                   input colon_on, input motion_fault, input finished, output ready);
endinterface

`default_nettype wire

// File: rtl/core/ctwd_bcd_to_bin.sv
`default_nettype none

// HH:MM digits to the binary value of the decimal number HHMM.
module ctwd_bcd_to_bin (
   input  ctwd_pkg::time_digits_type      digits,
   output logic [ctwd_pkg::DISPLAY_W-1:0] value
);

   localparam int W = ctwd_pkg::DISPLAY_W;

   logic [W-1:0] thousands;
   logic [W-1:0] hundreds;
   logic [W-1:0] tens;
   logic [W-1:0] ones;

   assign thousands = W'(digits.hours_tens) * W'(1000);
   assign hundreds  = W'(digits.hours_ones) * W'(100);
   assign tens      = W'(digits.minutes_tens) * W'(10);
   assign ones      = W'(digits.minutes_ones);

   assign value = thousands + hundreds + tens + ones;

endmodule

`default_nettype wire

// File: rtl/core/countdown_timer_motion_watchdog_unit.sv
// Response: a request accepted at a clock edge has its response valid after that edge.
// Throughput: one request per cycle while the response side is ready; the single response register
// refills in the cycle it is taken, and back-pressure on it stalls new requests.
// Reset: synchronous, active high; presets return to 12:34 and buzzer length 120,
// the countdown is stopped and the response register is emptied.
`default_nettype none
`include "countdown_timer_motion_watchdog_unit_defines.svh"

module countdown_timer_motion_watchdog_unit (
   input  logic                               clock,
   input  logic                               reset,
   ctwd_req_if.sink                           req_chan,
   ctwd_rsp_if.source                         rsp_chan,
   input  logic                               csr_we,
   input  logic [ctwd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ctwd_pkg::CSR_DATA_W-1:0]    csr_data
);

   // configuration
   ctwd_pkg::time_digits_type preset_ff;
   logic [7:0]                buzzer_length_ff;

   // countdown state
   ctwd_pkg::time_digits_type digits_ff, digits_in;
   logic [5:0] seconds_ff, seconds_in;
   logic       run_ff, run_in;
   logic       motion_seen_ff, motion_seen_in;
   logic       last_level_ff, last_level_in;
   logic       alarm_ff, alarm_in;
   logic [7:0] alarm_ticks_ff, alarm_ticks_in;
   logic       buzzer_ff, buzzer_in;
   logic       colon_ff, colon_in;
   logic       fault_in, done_in;

   // response register
   logic                           rsp_valid_ff;
   logic [ctwd_pkg::DISPLAY_W-1:0] display_ff, display_in;
   logic                           fault_ff, done_ff;
   logic                           rsp_run_ff, rsp_buzzer_ff, rsp_colon_ff;

   logic accept;
   logic time_zero;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign time_zero = (digits_ff == '0) && (seconds_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         preset_ff        <= ctwd_pkg::DIGITS_RESET;
         buzzer_length_ff <= ctwd_pkg::BUZZER_LENGTH_RESET;
      end else if (csr_we) begin
         case (csr_index)
            ctwd_pkg::CSR_PRESET_HOURS_TENS: begin
               preset_ff.hours_tens <= (csr_data[3:0] > ctwd_pkg::DIGIT_TOP) ?
                                       ctwd_pkg::DIGIT_TOP : csr_data[3:0];
            end
            ctwd_pkg::CSR_PRESET_HOURS_ONES: begin
               preset_ff.hours_ones <= (csr_data[3:0] > ctwd_pkg::DIGIT_TOP) ?
                                       ctwd_pkg::DIGIT_TOP : csr_data[3:0];
            end
            ctwd_pkg::CSR_PRESET_MINUTES_TENS: begin
               preset_ff.minutes_tens <= (csr_data[2:0] > ctwd_pkg::MINUTES_TENS_TOP) ?
                                         ctwd_pkg::MINUTES_TENS_TOP : csr_data[2:0];
            end
            ctwd_pkg::CSR_PRESET_MINUTES_ONES: begin
               preset_ff.minutes_ones <= (csr_data[3:0] > ctwd_pkg::DIGIT_TOP) ?
                                         ctwd_pkg::DIGIT_TOP : csr_data[3:0];
            end
            ctwd_pkg::CSR_BUZZER_LENGTH: begin
               buzzer_length_ff <= csr_data[7:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      digits_in      = digits_ff;
      seconds_in     = seconds_ff;
      run_in         = run_ff;
      motion_seen_in = motion_seen_ff;
      last_level_in  = last_level_ff;
      alarm_in       = alarm_ff;
      alarm_ticks_in = alarm_ticks_ff;
      buzzer_in      = buzzer_ff;
      colon_in       = colon_ff;
      fault_in       = 1'b0;
      done_in        = 1'b0;
      if (accept) begin
         case (req_chan.cmd)
            ctwd_pkg::CMD_START: begin
               if (!run_ff && !alarm_ff) begin
                  digits_in      = preset_ff;
                  seconds_in     = '0;
                  run_in         = 1'b1;
                  motion_seen_in = 1'b1;
               end
            end
            ctwd_pkg::CMD_STOP: begin
               run_in = 1'b0;
            end
            ctwd_pkg::CMD_TICK: begin
               if (alarm_ff) begin
                  // buzzer phase: ticks sound the buzzer, no counting
                  buzzer_in = 1'b1;
                  if (alarm_ticks_ff >= buzzer_length_ff) begin
                     buzzer_in      = 1'b0;
                     alarm_in       = 1'b0;
                     alarm_ticks_in = '0;
                  end else begin
                     alarm_ticks_in = alarm_ticks_ff + 8'd1;
                  end
               end else if (run_ff) begin
                  if (!motion_seen_ff && (req_chan.sensor_level != last_level_ff)) begin
                     motion_seen_in = 1'b1;
                     last_level_in  = req_chan.sensor_level;
                  end
                  if (time_zero) begin
                     alarm_in = 1'b1;
                     run_in   = 1'b0;
                     done_in  = 1'b1;
                  end else if (seconds_ff == '0) begin
                     // minute boundary: watchdog check, then borrow through digits
                     seconds_in = ctwd_pkg::SECONDS_TOP;
                     if (!motion_seen_in) begin
                        alarm_in = 1'b1;
                        run_in   = 1'b0;
                        fault_in = 1'b1;
                     end
                     motion_seen_in = 1'b0;
                     if (digits_ff.minutes_ones == '0) begin
                        digits_in.minutes_ones = ctwd_pkg::DIGIT_TOP;
                        if (digits_ff.minutes_tens == '0) begin
                           digits_in.minutes_tens = ctwd_pkg::MINUTES_TENS_TOP;
                           if (digits_ff.hours_ones == '0) begin
                              digits_in.hours_ones = ctwd_pkg::DIGIT_TOP;
                              if (digits_ff.hours_tens == '0) begin
                                 digits_in.hours_tens = ctwd_pkg::DIGIT_TOP;
                              end else begin
                                 digits_in.hours_tens = digits_ff.hours_tens - 4'd1;
                              end
                           end else begin
                              digits_in.hours_ones = digits_ff.hours_ones - 4'd1;
                           end
                        end else begin
                           digits_in.minutes_tens = digits_ff.minutes_tens - 3'd1;
                        end
                     end else begin
                        digits_in.minutes_ones = digits_ff.minutes_ones - 4'd1;
                     end
                  end else begin
                     seconds_in = seconds_ff - 6'd1;
                  end
                  colon_in = !colon_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   ctwd_bcd_to_bin u_bcd_to_bin (
      .digits (digits_in),
      .value  (display_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         digits_ff      <= ctwd_pkg::DIGITS_RESET;
         seconds_ff     <= '0;
         run_ff         <= 1'b0;
         motion_seen_ff <= 1'b1;
         last_level_ff  <= 1'b0;
         alarm_ff       <= 1'b0;
         alarm_ticks_ff <= '0;
         buzzer_ff      <= 1'b0;
         colon_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         digits_ff      <= digits_in;
         seconds_ff     <= seconds_in;
         run_ff         <= run_in;
         motion_seen_ff <= motion_seen_in;
         last_level_ff  <= last_level_in;
         alarm_ff       <= alarm_in;
         alarm_ticks_ff <= alarm_ticks_in;
         buzzer_ff      <= buzzer_in;
         colon_ff       <= colon_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         display_ff    <= display_in;
         rsp_run_ff    <= run_in;
         rsp_buzzer_ff <= buzzer_in;
         rsp_colon_ff  <= colon_in;
         fault_ff      <= fault_in;
         done_ff       <= done_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.display_value = display_ff;
   assign rsp_chan.running       = rsp_run_ff;
   assign rsp_chan.buzzer_on     = rsp_buzzer_ff;
   assign rsp_chan.colon_on      = rsp_colon_ff;
   assign rsp_chan.motion_fault  = fault_ff;
   assign rsp_chan.finished      = done_ff;

   `CTWD_ASSERT(a_run_alarm_excl, clock, reset, !(run_ff && alarm_ff), "run and alarm both set")
   `CTWD_ASSERT(a_buzzer_in_alarm, clock, reset, !buzzer_ff || alarm_ff, "buzzer without alarm")
   `CTWD_ASSERT(a_seconds_range, clock, reset, seconds_ff <= ctwd_pkg::SECONDS_TOP, "seconds range")
   `CTWD_ASSERT(a_alarm_rsp, clock, reset, rsp_valid_ff && (fault_ff || done_ff) |-> alarm_ff && !rsp_run_ff, "alarm response without alarm state")
   `CTWD_ASSERT(a_stop_clears, clock, reset, accept && (req_chan.cmd == ctwd_pkg::CMD_STOP) |=> !run_ff, "stop did not clear run")

endmodule

`default_nettype wire
